[rtl/core/lcdseq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared constants, types and helpers of the character LCD command sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_SLOTS = 8;

  localparam int COL_W      = 6;
  localparam int ROW_W      = 2;
  localparam int ACTION_W   = 3;
  localparam int BYTE_W     = 8;
  localparam int SLOT_W     = $clog2(GLYPH_SLOTS);
  localparam int GROW_W     = $clog2(GLYPH_ROWS);
  localparam int MAX_WRITES = 3;
  localparam int CNT_W      = 2;
  localparam int IDX_W      = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;
  localparam logic [COL_W-1:0]     COLUMNS_RESET = 6'd16;
  localparam logic [ROW_W-1:0]     ROWS_RESET    = 2'd2;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_RAW    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TEXT   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_VISUAL = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_GLYPH  = 3'd5;

  // Bus bytes and flags.
  localparam logic [BYTE_W-1:0] DDRAM_FLAG   = 8'h80;
  localparam logic [BYTE_W-1:0] CGRAM_FLAG   = 8'h40;
  localparam logic [BYTE_W-1:0] CLEAR_CMD    = 8'h01;
  localparam logic [BYTE_W-1:0] VISUAL_BASE  = 8'h08;
  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [GROW_W-1:0] GLYPH_LAST_ROW = GROW_W'(GLYPH_ROWS - 1);

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   char_code;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [SLOT_W-1:0]   glyph_index;
    logic [GROW_W-1:0]   glyph_row;
    logic                display_on;
    logic                cursor_on;
    logic                blink_on;
  } item_t;

  typedef struct packed {
    logic              reg_select;
    logic [BYTE_W-1:0] bus_byte;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } write_t;

  typedef struct packed {
    write_t [MAX_WRITES-1:0] w;
    logic [CNT_W-1:0]        cnt;
    logic [COL_W-1:0]        col_next;
    logic [ROW_W-1:0]        row_next;
  } plan_t;

  // DDRAM address: column plus row times 0x40, with the set-address flag.
  function automatic logic [BYTE_W-1:0] ddram_addr(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
    logic [BYTE_W-1:0] sum;
    sum = {2'b00, c} + {r, 6'b000000};
    return sum | DDRAM_FLAG;
  endfunction

endpackage
`default_nettype wire

[rtl/core/lcdseq_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_in_if
// Command channel: valid/ready handshake with one command per transaction.
// ----------------------------------------------------------------------------
interface lcdseq_in_if
  import lcdseq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   char_code;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic [SLOT_W-1:0]   glyph_index;
  logic [GROW_W-1:0]   glyph_row;
  logic                display_on;
  logic                cursor_on;
  logic                blink_on;

  modport source (output valid, action, char_code, col, row, glyph_index, glyph_row,
                  display_on, cursor_on, blink_on, input ready);
  modport sink   (input valid, action, char_code, col, row, glyph_index, glyph_row,
                  display_on, cursor_on, blink_on, output ready);
endinterface
`default_nettype wire

[rtl/core/lcdseq_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_out_if
// Bus write channel: valid/ready handshake with one bus write per transaction.
// ----------------------------------------------------------------------------
interface lcdseq_out_if
  import lcdseq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              reg_select;
  logic [BYTE_W-1:0] bus_byte;
  logic              last;
  logic [COL_W-1:0]  cursor_col_now;
  logic [ROW_W-1:0]  cursor_row_now;

  modport source (output valid, reg_select, bus_byte, last, cursor_col_now, cursor_row_now,
                  input ready);
  modport sink   (input valid, reg_select, bus_byte, last, cursor_col_now, cursor_row_now,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/char_lcd_cursor_command_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_cursor_command_sequencer
// Front end of a character LCD controller that turns commands into bus writes.
// ----------------------------------------------------------------------------
// Each command transaction on in_ch produces up to three bus write
// transactions on out_ch, each marked as an instruction (reg_select low) or
// data (reg_select high) write, with last set on the final write of the
// command and the tracked cursor position after that write. The first write
// of a command passes through the input register, the write list and the
// output register. The output register issues one bus write per cycle while
// the bus takes them; a command has one write for a visual setting, set cursor
// or newline, one or two for a character, two for clear and two or three for
// a glyph row. Commands with unused action codes produce no writes.
// A new command is accepted while the previous one is still being issued.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) must only happen while
// the block is idle; index 0 sets the column count, index 1 the row count.
// ----------------------------------------------------------------------------
module char_lcd_cursor_command_sequencer
  import lcdseq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lcdseq_in_if.sink             in_ch,
  lcdseq_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [COL_W-1:0] cols_r;
  logic [ROW_W-1:0] rows_r;

  // Input register and tracked cursor.
  item_t            item_r;
  logic             item_valid_r, item_valid_nxt;
  logic [COL_W-1:0] cur_col_r;
  logic [ROW_W-1:0] cur_row_r;

  logic   in_accept;
  logic   take;
  plan_t  plan;
  write_t out_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLUMNS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: cols_r <= cfg_wdata[COL_W-1:0];
        CFG_ROWS:    rows_r <= cfg_wdata[ROW_W-1:0];
        default:     cols_r <= cols_r;
      endcase
    end
  end

  // The input register frees up in the same cycle its command moves into
  // the write list, so commands can follow each other without a gap.
  assign in_ch.ready = !item_valid_r || take;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_accept) begin
      item_valid_nxt = 1'b1;
    end else if (take) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      // The cursor moves when a command's writes are committed, so the next
      // command is decoded against the updated position.
      if (take) begin
        cur_col_r <= plan.col_next;
        cur_row_r <= plan.row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= '{action: in_ch.action, char_code: in_ch.char_code, col: in_ch.col,
                  row: in_ch.row, glyph_index: in_ch.glyph_index,
                  glyph_row: in_ch.glyph_row, display_on: in_ch.display_on,
                  cursor_on: in_ch.cursor_on, blink_on: in_ch.blink_on};
    end
  end

  lcdseq_decode u_decode (
    .item    (item_r),
    .cur_col (cur_col_r),
    .cur_row (cur_row_r),
    .cols    (cols_r),
    .rows    (rows_r),
    .plan    (plan)
  );

  lcdseq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_req  (item_valid_r),
    .plan      (plan),
    .load_take (take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_write (out_write),
    .out_last  (out_ch.last)
  );

  assign out_ch.reg_select     = out_write.reg_select;
  assign out_ch.bus_byte       = out_write.bus_byte;
  assign out_ch.cursor_col_now = out_write.col;
  assign out_ch.cursor_row_now = out_write.row;

endmodule
`default_nettype wire

[rtl/core/lcdseq_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_decode
// Expands one registered command into its list of bus writes and the new
// cursor position.
// ----------------------------------------------------------------------------
module lcdseq_decode
  import lcdseq_pkg::*;
(
  input  item_t            item,
  input  logic [COL_W-1:0] cur_col,
  input  logic [ROW_W-1:0] cur_row,
  input  logic [COL_W-1:0] cols,
  input  logic [ROW_W-1:0] rows,
  output plan_t            plan
);

  logic [COL_W:0]   col_inc;
  logic             col_wraps;
  logic [ROW_W:0]   row_inc;
  logic [ROW_W-1:0] nl_row;
  logic [COL_W-1:0] set_col;
  logic [ROW_W-1:0] set_row;
  logic [COL_W-1:0] home_col;
  logic [ROW_W-1:0] home_row;
  write_t           nl_write;
  write_t           data_write;
  write_t           hold_write;

  always_comb begin
    col_inc   = {1'b0, cur_col} + 7'd1;
    col_wraps = (col_inc >= {1'b0, cols});
    row_inc   = {1'b0, cur_row} + 3'd1;
    nl_row    = (row_inc >= {1'b0, rows}) ? '0 : row_inc[ROW_W-1:0];

    // Requested positions are taken only when inside the configured area.
    set_col  = (item.col < cols) ? item.col : cur_col;
    set_row  = (item.row < rows) ? item.row : cur_row;
    home_col = (cols != '0) ? '0 : cur_col;
    home_row = (rows != '0) ? '0 : cur_row;

    nl_write   = '{reg_select: RS_INSTR, bus_byte: ddram_addr('0, nl_row),
                   col: '0, row: nl_row};
    data_write = '{reg_select: RS_DATA, bus_byte: item.char_code,
                   col: col_inc[COL_W-1:0], row: cur_row};
    hold_write = '{reg_select: RS_INSTR, bus_byte: '0, col: cur_col, row: cur_row};

    plan.w        = {MAX_WRITES{hold_write}};
    plan.cnt      = '0;
    plan.col_next = cur_col;
    plan.row_next = cur_row;

    case (item.action)
      ACT_RAW, ACT_TEXT: begin
        if (item.action == ACT_TEXT && item.char_code == NEWLINE_CODE) begin
          plan.w[0]     = nl_write;
          plan.cnt      = 2'd1;
          plan.col_next = '0;
          plan.row_next = nl_row;
        end else if (col_wraps) begin
          plan.w[0]     = data_write;
          plan.w[1]     = nl_write;
          plan.cnt      = 2'd2;
          plan.col_next = '0;
          plan.row_next = nl_row;
        end else begin
          plan.w[0]     = data_write;
          plan.cnt      = 2'd1;
          plan.col_next = col_inc[COL_W-1:0];
        end
      end
      ACT_SET: begin
        plan.w[0]     = '{reg_select: RS_INSTR, bus_byte: ddram_addr(set_col, set_row),
                          col: set_col, row: set_row};
        plan.cnt      = 2'd1;
        plan.col_next = set_col;
        plan.row_next = set_row;
      end
      ACT_CLEAR: begin
        plan.w[0].bus_byte = CLEAR_CMD;
        plan.w[1]     = '{reg_select: RS_INSTR, bus_byte: ddram_addr(home_col, home_row),
                          col: home_col, row: home_row};
        plan.cnt      = 2'd2;
        plan.col_next = home_col;
        plan.row_next = home_row;
      end
      ACT_VISUAL: begin
        plan.w[0].bus_byte = VISUAL_BASE | {5'b00000, item.display_on, item.cursor_on,
                                            item.blink_on};
        plan.cnt = 2'd1;
      end
      ACT_GLYPH: begin
        plan.w[0].bus_byte   = CGRAM_FLAG | {2'b00, item.glyph_index, item.glyph_row};
        plan.w[1].reg_select = RS_DATA;
        plan.w[1].bus_byte   = item.char_code;
        plan.w[2].bus_byte   = ddram_addr(cur_col, cur_row);
        plan.cnt = (item.glyph_row == GLYPH_LAST_ROW) ? 2'd3 : 2'd2;
      end
      default: begin
        plan.cnt = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/lcdseq_emit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_emit
// Holds the write list of one command and issues it one bus write per cycle
// through the output register while the bus takes them.
// ----------------------------------------------------------------------------
module lcdseq_emit
  import lcdseq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load_req,
  input  plan_t  plan,
  output logic   load_take,
  output logic   out_valid,
  input  logic   out_ready,
  output write_t out_write,
  output logic   out_last
);

  plan_t            plan_r;
  logic             plan_valid_r, plan_valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  write_t           out_write_r;
  logic             out_last_r;
  logic             pop;
  logic             last_entry;

  always_comb begin
    pop        = plan_valid_r && (!out_valid_r || out_ready);
    last_entry = (idx_r == IDX_W'(plan_r.cnt - 2'd1));
    load_take  = load_req && (!plan_valid_r || (pop && last_entry));

    plan_valid_nxt = plan_valid_r;
    idx_nxt        = idx_r;
    if (load_take) begin
      plan_valid_nxt = (plan.cnt != '0);
      idx_nxt        = '0;
    end else if (pop) begin
      idx_nxt = idx_r + 2'd1;
      if (last_entry) begin
        plan_valid_nxt = 1'b0;
      end
    end

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_valid_r <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      plan_valid_r <= plan_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_take) begin
      plan_r <= plan;
    end
    if (pop) begin
      out_write_r <= plan_r.w[idx_r];
      out_last_r  <= last_entry;
    end
  end

  assign out_valid = out_valid_r;
  assign out_write = out_write_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

[rtl/core/lcdseq_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_checker
// Port-level checks of the bus write channel of the command sequencer.
// ----------------------------------------------------------------------------
module lcdseq_checker
  import lcdseq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_last,
  input wire logic              out_reg_select,
  input wire logic [BYTE_W-1:0] out_bus_byte
);

  // Nothing is offered on the bus right after reset.
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("bus write offered right after reset");

  // The writes of one command come out without a gap once the bus takes them.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside the writes of one command");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("bus write withdrawn before it was taken");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bus_byte) && $stable(out_reg_select)
                                && $stable(out_last))
    else $error("stalled bus write changed");

endmodule

bind char_lcd_cursor_command_sequencer lcdseq_checker u_lcdseq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_last       (out_ch.last),
  .out_reg_select (out_ch.reg_select),
  .out_bus_byte   (out_ch.bus_byte)
);
`default_nettype wire
